>>> rtl/core/cc20_pkg.sv
// Shared types, constants and round functions for the ChaCha20 stream cipher.
`timescale 1ns / 1ps

package cc20_pkg;

  // The 16-word ChaCha state; word i sits in bits [32*i+31:32*i].
  typedef logic [15:0][31:0] cc20_state_t;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t RegKey0     = 3'd0;
  localparam cfg_idx_t RegKey1     = 3'd1;
  localparam cfg_idx_t RegKey2     = 3'd2;
  localparam cfg_idx_t RegKey3     = 3'd3;
  localparam cfg_idx_t RegNonceLo  = 3'd4;
  localparam cfg_idx_t RegNonceHi  = 3'd5;
  localparam cfg_idx_t RegStartCnt = 3'd6;

  localparam logic [3:0] MaxBytes = 4'd8;

  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646e;
  localparam logic [31:0] Sigma2 = 32'h7962_2d32;
  localparam logic [31:0] Sigma3 = 32'h6b20_6574;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_ADD
  } core_state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  // Half of a quarter round: the first half rotates by 16 and 12,
  // the second half by 8 and 7.
  function automatic qr_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] d,
                                  input logic second);
    logic [31:0] a1;
    logic [31:0] b1;
    logic [31:0] c1;
    logic [31:0] d1;
    qr_t         r;
    a1 = a + b;
    d1 = d ^ a1;
    d1 = second ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
    c1 = c + d1;
    b1 = b ^ c1;
    b1 = second ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
    r.a = a1;
    r.b = b1;
    r.c = c1;
    r.d = d1;
    return r;
  endfunction

  // Initial block state from key, counter and nonce.
  function automatic cc20_state_t build_state(
      input logic [63:0] k0, input logic [63:0] k1,
      input logic [63:0] k2, input logic [63:0] k3,
      input logic [31:0] ctr, input logic [63:0] n_lo, input logic [31:0] n_hi);
    cc20_state_t s;
    s[0]  = Sigma0;
    s[1]  = Sigma1;
    s[2]  = Sigma2;
    s[3]  = Sigma3;
    s[4]  = k0[31:0];
    s[5]  = k0[63:32];
    s[6]  = k1[31:0];
    s[7]  = k1[63:32];
    s[8]  = k2[31:0];
    s[9]  = k2[63:32];
    s[10] = k3[31:0];
    s[11] = k3[63:32];
    s[12] = ctr;
    s[13] = n_lo[31:0];
    s[14] = n_lo[63:32];
    s[15] = n_hi;
    return s;
  endfunction

endpackage

>>> rtl/core/cc20_block.sv
// ChaCha20 block generator: one shared four-lane half-quarter-round unit.
`timescale 1ns / 1ps

module cc20_block #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  cc20_pkg::cc20_state_t init_i,
  output logic                 done_o,
  output cc20_pkg::cc20_state_t ks_o
);
  import cc20_pkg::*;

  localparam int RndW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  core_state_e state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  cc20_state_t x_q, x_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      phase_q <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // Phase bit 1 selects column or diagonal lanes, bit 0 the rotation half.
  always_comb begin
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    qr_t        qr;
    ia      = '0;
    ib      = '0;
    ic      = '0;
    id      = '0;
    qr      = '0;
    state_d = state_q;
    phase_d = phase_q;
    rnd_d   = rnd_q;
    x_d     = x_q;
    done_o  = 1'b0;
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          x_d     = init_i;
          phase_d = '0;
          rnd_d   = '0;
          state_d = CS_ROUND;
        end
      end
      CS_ROUND: begin
        for (int l = 0; l < 4; l++) begin
          ia = 4'(l);
          if (phase_q[1]) begin
            ib = 4'(4 + ((l + 1) & 3));
            ic = 4'(8 + ((l + 2) & 3));
            id = 4'(12 + ((l + 3) & 3));
          end else begin
            ib = 4'(4 + l);
            ic = 4'(8 + l);
            id = 4'(12 + l);
          end
          qr = qr_half(x_q[ia], x_q[ib], x_q[ic], x_q[id], phase_q[0]);
          x_d[ia] = qr.a;
          x_d[ib] = qr.b;
          x_d[ic] = qr.c;
          x_d[id] = qr.d;
        end
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          rnd_d = rnd_q + 1'b1;
          if (rnd_q == RndW'(DOUBLE_ROUNDS - 1)) begin
            state_d = CS_ADD;
          end
        end
      end
      CS_ADD: begin
        for (int i = 0; i < 16; i++) begin
          x_d[i] = x_q[i] + init_i[i];
        end
        done_o  = 1'b1;
        state_d = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  assign ks_o = x_q;

endmodule

>>> rtl/core/chacha20_stream_cipher.sv
// Top level of the ChaCha20 stream cipher: item handshake, counters and output register.
// An item at the start of a 64-byte block waits in ST_GEN while the shared round unit,
// doing half a round per cycle, builds the block in CS_ROUND and CS_ADD; any other item
// goes from ST_IDLE straight to ST_EMIT. ST_EMIT waits until the output register is free,
// and a new item is taken only in ST_IDLE, once the last one has reached that register.
// Reset (rst_ni low, asynchronous): state, config and counters clear; next item starts a block.
`timescale 1ns / 1ps

module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_in_i,
  input  logic [3:0]  byte_count_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] data_out_o,
  output logic [3:0]  out_count_o,
  output logic        out_last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import cc20_pkg::*;

  // Configuration registers.
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0] nonce_hi_q, start_cnt_q;

  // Block counter and 8-byte slot position inside the current keystream block.
  logic [31:0] blk_cnt_q, blk_cnt_d;
  logic [2:0]  pos_q, pos_d;

  top_state_e state_q, state_d;

  // The item being worked on.
  logic [63:0] item_data_q;
  logic [3:0]  item_cnt_q;
  logic        item_last_q;

  // Output register, which lets the next item come in while a result waits.
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;
  logic [3:0]  out_cnt_q, out_cnt_d;
  logic        out_last_q, out_last_d;

  logic        in_xfer;
  logic        blk_start;
  logic        blk_done;
  cc20_state_t init_state;
  cc20_state_t ks;
  logic [63:0] ks_pair;
  logic [63:0] byte_mask;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // A new keystream block is needed when the item lands on slot zero.
  assign blk_start  = in_xfer && (pos_q == 3'd0);

  assign init_state = build_state(key0_q, key1_q, key2_q, key3_q, blk_cnt_q,
                                  nonce_lo_q, nonce_hi_q);

  cc20_block #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_block (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(blk_start),
    .init_i (init_state),
    .done_o (blk_done),
    .ks_o   (ks)
  );

  // Keystream words 2p and 2p+1 form the 8 bytes for slot p.
  assign ks_pair = {ks[{pos_q, 1'b1}], ks[{pos_q, 1'b0}]};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_mask[8*b +: 8] = (4'(b) < item_cnt_q) ? 8'hff : 8'h00;
    end
  end

  // Configuration writes; start_counter is handled with the counters below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q      <= '0;
      key1_q      <= '0;
      key2_q      <= '0;
      key3_q      <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      start_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegKey0:     key0_q      <= cfg_data_i;
        RegKey1:     key1_q      <= cfg_data_i;
        RegKey2:     key2_q      <= cfg_data_i;
        RegKey3:     key3_q      <= cfg_data_i;
        RegNonceLo:  nonce_lo_q  <= cfg_data_i;
        RegNonceHi:  nonce_hi_q  <= cfg_data_i[31:0];
        RegStartCnt: start_cnt_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      blk_cnt_q   <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_cnt_q   <= blk_cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Byte counts above eight are treated as eight.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_data_q <= data_in_i;
      item_cnt_q  <= (byte_count_i > MaxBytes) ? MaxBytes : byte_count_i;
      item_last_q <= end_of_message_i;
    end
    out_data_q <= out_data_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  // Sequencer: an accepted item either waits for a fresh keystream block or
  // goes straight to the output register once that register is free.
  always_comb begin
    state_d     = state_q;
    blk_cnt_d   = blk_cnt_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = blk_start ? ST_GEN : ST_EMIT;
        end
      end
      ST_GEN: begin
        if (blk_done) begin
          // The counter wraps at 2^32 and never carries into the nonce.
          blk_cnt_d = blk_cnt_q + 32'd1;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = (item_data_q ^ ks_pair) & byte_mask;
          out_cnt_d   = item_cnt_q;
          out_last_d  = item_last_q;
          // A partial item still uses up its whole slot; the message end
          // reloads the counter and forces a new block.
          if (item_last_q) begin
            blk_cnt_d = start_cnt_q;
            pos_d     = 3'd0;
          end else begin
            pos_d = pos_q + 3'd1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Writing the start counter begins a new message from that value.
    if (cfg_we_i && (cfg_index_i == RegStartCnt)) begin
      blk_cnt_d = cfg_data_i[31:0];
      pos_d     = 3'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/core/cc20_checker.sv
// Port-level checker for the ChaCha20 stream cipher, bound to the top level.
`timescale 1ns / 1ps

module cc20_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] data_out_o,
  input logic [3:0]  out_count_o
);

  // A held result stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // The byte count is capped at eight.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_count_o <= 4'd8)
    else $error("output byte count above eight");

  // An empty item has all bytes cleared.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_count_o == 4'd0) |-> data_out_o == 64'd0)
    else $error("empty item carries data");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .data_out_o (data_out_o),
  .out_count_o(out_count_o)
);
